// ----- hw/rtl/sct_pkg.sv -----
`default_nettype none
package sct_pkg;

  localparam int MAX_INPUT_LENGTH_DEF = 65536;
  localparam int QUEUE_DEPTH_DEF      = 4;
  localparam int SLOTS                = 3;

  // token types
  localparam logic [4:0] T_WORD    = 5'd0;
  localparam logic [4:0] T_PIPE    = 5'd1;
  localparam logic [4:0] T_OR      = 5'd2;
  localparam logic [4:0] T_AMP     = 5'd3;
  localparam logic [4:0] T_AND     = 5'd4;
  localparam logic [4:0] T_SEMI    = 5'd5;
  localparam logic [4:0] T_DSEMI   = 5'd6;
  localparam logic [4:0] T_NEWLINE = 5'd7;
  localparam logic [4:0] T_RIN     = 5'd8;
  localparam logic [4:0] T_ROUT    = 5'd9;
  localparam logic [4:0] T_APPEND  = 5'd10;
  localparam logic [4:0] T_HEREDOC = 5'd11;
  localparam logic [4:0] T_DUPIN   = 5'd12;
  localparam logic [4:0] T_DUPOUT  = 5'd13;
  localparam logic [4:0] T_LPAREN  = 5'd14;
  localparam logic [4:0] T_RPAREN  = 5'd15;
  localparam logic [4:0] T_EOF     = 5'd16;
  localparam logic [4:0] T_ERROR   = 5'd17;

  // scan modes
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_COMMENT = 3'd1;
  localparam logic [2:0] M_WORD    = 3'd2;
  localparam logic [2:0] M_WESC    = 3'd3;
  localparam logic [2:0] M_SQ      = 3'd4;
  localparam logic [2:0] M_DQ      = 3'd5;
  localparam logic [2:0] M_DQESC   = 3'd6;

  // pending operator codes
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_PIPE = 3'd1;
  localparam logic [2:0] OP_AMP  = 3'd2;
  localparam logic [2:0] OP_SEMI = 3'd3;
  localparam logic [2:0] OP_LT   = 3'd4;
  localparam logic [2:0] OP_GT   = 3'd5;

  // characters
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  typedef struct packed {
    logic [4:0]  ttype;
    logic [15:0] start;
    logic [15:0] length;
  } tok_t;

  // all tokens caused by one input item, count is 1..3
  typedef struct packed {
    tok_t [SLOTS-1:0] slot;
    logic [1:0]       count;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/shell_command_tokenizer.sv -----
// the tokens of an accepted item pass through the token queue and then the output register to out_
// throughput: one byte per cycle while in_stall is low; an item causing k tokens takes k output beats
// a four-entry queue of token groups parts the scanner from the output serializer
// reset: synchronous, rst_n low clears scan state, offsets, queue and out_valid
`default_nettype none
module shell_command_tokenizer
  import sct_pkg::*;
#(
  parameter int MAX_INPUT_LENGTH = MAX_INPUT_LENGTH_DEF,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_has_char,
  input  wire logic        in_end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_token_type,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic             out_last_of_run
);

  // front: byte classification and scan state, builds the token group of each beat
  // queue: token groups waiting for the serializer
  // back: walks each group one token per beat into the output register

  logic    push, pop;
  bundle_t push_data, head;
  q_stat_t q_stat;

  sct_front #(
    .MAX_INPUT_LENGTH(MAX_INPUT_LENGTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_has_char     (in_has_char),
    .in_end_of_input (in_end_of_input),
    .q_stat          (q_stat),
    .push            (push),
    .push_data       (push_data)
  );

  // beats that cause no token never enter the queue
  sct_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // output register doubles as the skid stage toward the consumer
  sct_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_stat           (q_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_type   (out_token_type),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/sct_front.sv -----
`default_nettype none
module sct_front
  import sct_pkg::*;
#(
  parameter int MAX_INPUT_LENGTH = MAX_INPUT_LENGTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire logic [7:0] in_ch,
  input  wire logic    in_has_char,
  input  wire logic    in_end_of_input,
  input  q_stat_t      q_stat,
  output logic         push,
  output bundle_t      push_data
);

  localparam logic [15:0] POS_LIMIT =
    (MAX_INPUT_LENGTH < 65535) ? 16'(MAX_INPUT_LENGTH) : 16'hFFFF;

  logic [2:0]  mode_r, mode_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [15:0] tb_r, tb_nxt;
  logic [15:0] pos_r, pos_nxt;

  logic        blank, nl, lp, rp, delim, run_idle;
  logic [2:0]  opc;
  logic [5:0]  dt;
  logic [15:0] pn, p2;
  logic [3:0]  tok_v;
  tok_t [3:0]  tok;
  logic [1:0]  n;

  function automatic logic [4:0] single_type(input logic [2:0] op);
    logic [4:0] t;
    case (op)
      OP_PIPE: t = T_PIPE;
      OP_AMP:  t = T_AMP;
      OP_SEMI: t = T_SEMI;
      OP_LT:   t = T_RIN;
      default: t = T_ROUT;
    endcase
    return t;
  endfunction

  // msb flags a two-byte operator
  function automatic logic [5:0] double_type(input logic [2:0] op, input logic [7:0] c);
    logic [5:0] r;
    r = {1'b0, T_WORD};
    if (op == OP_PIPE && c == CH_PIPE) r = {1'b1, T_OR};
    if (op == OP_AMP  && c == CH_AMP)  r = {1'b1, T_AND};
    if (op == OP_SEMI && c == CH_SEMI) r = {1'b1, T_DSEMI};
    if (op == OP_LT   && c == CH_LT)   r = {1'b1, T_HEREDOC};
    if (op == OP_LT   && c == CH_AMP)  r = {1'b1, T_DUPIN};
    if (op == OP_GT   && c == CH_GT)   r = {1'b1, T_APPEND};
    if (op == OP_GT   && c == CH_AMP)  r = {1'b1, T_DUPOUT};
    return r;
  endfunction

  function automatic logic [2:0] word_mode(input logic [7:0] c);
    logic [2:0] m;
    case (c)
      CH_BSLASH: m = M_WESC;
      CH_SQUOTE: m = M_SQ;
      CH_DQUOTE: m = M_DQ;
      default:   m = M_WORD;
    endcase
    return m;
  endfunction

  always_comb begin
    blank = in_ch inside {CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};
    nl    = (in_ch == CH_NL);
    lp    = (in_ch == CH_LPAREN);
    rp    = (in_ch == CH_RPAREN);
    case (in_ch)
      CH_PIPE: opc = OP_PIPE;
      CH_AMP:  opc = OP_AMP;
      CH_SEMI: opc = OP_SEMI;
      CH_LT:   opc = OP_LT;
      CH_GT:   opc = OP_GT;
      default: opc = OP_NONE;
    endcase
    delim = blank | nl | lp | rp | (opc != OP_NONE);
    pn    = (pos_r >= POS_LIMIT) ? POS_LIMIT : pos_r + 16'd1;
    dt    = double_type(pend_r, in_ch);
  end

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    tb_nxt   = tb_r;
    run_idle = 1'b0;
    tok_v    = '0;
    tok      = '0;

    if (in_has_char) begin
      case (mode_r)
        M_COMMENT: begin
          if (nl) begin
            mode_nxt = M_IDLE;
            run_idle = 1'b1;
          end
        end
        M_WORD: begin
          if (delim) begin
            tok_v[0] = 1'b1;
            tok[0]   = '{ttype: T_WORD, start: tb_r, length: pos_r - tb_r};
            mode_nxt = M_IDLE;
            run_idle = 1'b1;
          end else begin
            mode_nxt = word_mode(in_ch);
          end
        end
        M_WESC: mode_nxt = M_WORD;
        M_SQ: begin
          if (in_ch == CH_SQUOTE) mode_nxt = M_WORD;
        end
        M_DQ: begin
          if (in_ch == CH_DQUOTE) mode_nxt = M_WORD;
          else if (in_ch == CH_BSLASH) mode_nxt = M_DQESC;
        end
        M_DQESC: mode_nxt = M_DQ;
        default: begin
          mode_nxt = M_IDLE;
          if (pend_r != OP_NONE) begin
            tok_v[0] = 1'b1;
            pend_nxt = OP_NONE;
            if (dt[5]) begin
              tok[0] = '{ttype: dt[4:0], start: tb_r, length: pn - tb_r};
            end else begin
              tok[0]   = '{ttype: single_type(pend_r), start: tb_r, length: pos_r - tb_r};
              run_idle = 1'b1;
            end
          end else begin
            run_idle = 1'b1;
          end
        end
      endcase

      // byte seen between tokens
      if (run_idle && !blank) begin
        if (nl || lp || rp) begin
          tok_v[1] = 1'b1;
          tok[1]   = '{ttype: nl ? T_NEWLINE : (lp ? T_LPAREN : T_RPAREN),
                       start: pos_r, length: pn - pos_r};
        end else if (opc != OP_NONE) begin
          pend_nxt = opc;
          tb_nxt   = pos_r;
        end else if (in_ch == CH_HASH) begin
          mode_nxt = M_COMMENT;
        end else begin
          tb_nxt   = pos_r;
          mode_nxt = word_mode(in_ch);
        end
      end
    end

    p2 = in_has_char ? pn : pos_r;

    // close the line: open token, then eof
    if (in_end_of_input) begin
      if (pend_nxt != OP_NONE) begin
        tok_v[2] = 1'b1;
        tok[2]   = '{ttype: single_type(pend_nxt), start: tb_nxt, length: p2 - tb_nxt};
      end else if (mode_nxt == M_WORD) begin
        tok_v[2] = 1'b1;
        tok[2]   = '{ttype: T_WORD, start: tb_nxt, length: p2 - tb_nxt};
      end else if (mode_nxt inside {M_WESC, M_SQ, M_DQ, M_DQESC}) begin
        tok_v[2] = 1'b1;
        tok[2]   = '{ttype: T_ERROR, start: tb_nxt, length: p2 - tb_nxt};
      end
      tok_v[3] = 1'b1;
      tok[3]   = '{ttype: T_EOF, start: p2, length: 16'd0};
    end

    pos_nxt = in_end_of_input ? 16'd0 : p2;
  end

  // pack present tokens into consecutive slots
  always_comb begin
    n         = 2'd0;
    push_data = '0;
    for (int i = 0; i < 4; i++) begin
      if (tok_v[i] && n != 2'd3) begin
        push_data.slot[n] = tok[i];
        n = n + 2'd1;
      end
    end
    push_data.count = n;
  end

  assign in_stall = q_stat.full;
  assign push     = in_valid && !in_stall && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pend_r <= OP_NONE;
      tb_r   <= 16'd0;
      pos_r  <= 16'd0;
    end else if (in_valid && !in_stall) begin
      if (in_end_of_input) begin
        mode_r <= M_IDLE;
        pend_r <= OP_NONE;
        tb_r   <= 16'd0;
      end else begin
        mode_r <= mode_nxt;
        pend_r <= pend_nxt;
        tb_r   <= tb_nxt;
      end
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sct_queue.sv -----
`default_nettype none
module sct_queue
  import sct_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  bundle_t   push_data,
  input  wire logic pop,
  output bundle_t   head,
  output q_stat_t   q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head         = mem[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sct_back.sv -----
`default_nettype none
module sct_back
  import sct_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  bundle_t     head,
  input  q_stat_t     q_stat,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [4:0]  out_token_type,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  logic [1:0] idx_r;
  logic       out_valid_r;
  tok_t       tok_r;
  logic       last_r;
  logic       load, last;

  assign load = !q_stat.empty && (!out_valid_r || !out_stall);
  assign last = (idx_r == head.count - 2'd1);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (load) idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= head.slot[idx_r];
      last_r <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_type   = tok_r.ttype;
  assign out_token_start  = tok_r.start;
  assign out_token_length = tok_r.length;
  assign out_last_of_run  = last_r;

endmodule
`default_nettype wire

// ----- hw/rtl/sct_checker.sv -----
`default_nettype none
module sct_checker
  import sct_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [4:0]  out_token_type,
  input wire logic [15:0] out_token_start,
  input wire logic [15:0] out_token_length,
  input wire logic        out_last_of_run
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_type) &&
      $stable(out_token_start) && $stable(out_token_length) && $stable(out_last_of_run))
    else $error("stalled result beat changed");

  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_type == T_EOF |-> out_token_length == 16'd0 && out_last_of_run)
    else $error("eof token malformed");

  a_op_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_type != T_WORD && out_token_type != T_ERROR &&
      out_token_type != T_EOF |-> out_token_length <= 16'd2)
    else $error("operator token longer than two bytes");

endmodule

bind shell_command_tokenizer sct_checker u_sct_checker (.*);
`default_nettype wire

// ----- verif/shell_command_tokenizer_tb.sv -----
module shell_command_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sct_pkg::*;

  // offsets stop climbing here
  localparam logic [15:0] POS_CEILING = (MAX_INPUT_LENGTH_DEF < 65535) ?
                                        16'(MAX_INPUT_LENGTH_DEF) : 16'hFFFF;
  // receiver hold-off that backs the token queue up into the input
  localparam int unsigned HOLD_CYCLES = 80;

  typedef struct packed {
    logic [4:0]  ttype;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_beat_t;

  // lexer state mirror plus the queue of tokens still owed by the block
  class token_scoreboard;
    logic [2:0]  mode;
    logic [2:0]  pend_op;
    logic [15:0] tok_begin;
    logic [15:0] line_pos;
    token_beat_t owed_q[$];
    token_beat_t step_q[$];
    int unsigned mismatches;
    int unsigned tokens_seen;
    bit [31:0]   kinds_seen;

    function new();
      mismatches = 0;
      tokens_seen = 0;
      kinds_seen = '0;
      clear_line();
    endfunction

    function void clear_line();
      mode = M_IDLE;
      pend_op = OP_NONE;
      tok_begin = '0;
      line_pos = '0;
    endfunction

    function logic [15:0] next_pos(logic [15:0] p);
      return (p >= POS_CEILING) ? POS_CEILING : p + 16'd1;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
    endfunction

    function logic [2:0] op_of(logic [7:0] c);
      case (c)
        CH_PIPE: return OP_PIPE;
        CH_AMP:  return OP_AMP;
        CH_SEMI: return OP_SEMI;
        CH_LT:   return OP_LT;
        CH_GT:   return OP_GT;
        default: return OP_NONE;
      endcase
    endfunction

    function bit ends_word(logic [7:0] c);
      return is_blank(c) || c == CH_NL || c == CH_LPAREN || c == CH_RPAREN ||
             op_of(c) != OP_NONE;
    endfunction

    function void add_token(logic [4:0] t, logic [15:0] s, logic [15:0] l);
      if (step_q.size() < SLOTS) step_q.push_back('{ttype: t, start: s, length: l, last: 1'b0});
    endfunction

    function logic [4:0] single_type(logic [2:0] op);
      case (op)
        OP_PIPE: return T_PIPE;
        OP_AMP:  return T_AMP;
        OP_SEMI: return T_SEMI;
        OP_LT:   return T_RIN;
        default: return T_ROUT;
      endcase
    endfunction

    // two-byte operator formed by the pending byte and c, if any
    function bit pair_type(logic [2:0] op, logic [7:0] c, output logic [4:0] t);
      pair_type = 1'b1;
      t = T_WORD;
      if (op == OP_PIPE && c == CH_PIPE) t = T_OR;
      else if (op == OP_AMP && c == CH_AMP) t = T_AND;
      else if (op == OP_SEMI && c == CH_SEMI) t = T_DSEMI;
      else if (op == OP_LT && c == CH_LT) t = T_HEREDOC;
      else if (op == OP_LT && c == CH_AMP) t = T_DUPIN;
      else if (op == OP_GT && c == CH_GT) t = T_APPEND;
      else if (op == OP_GT && c == CH_AMP) t = T_DUPOUT;
      else pair_type = 1'b0;
    endfunction

    function void enter_word(logic [7:0] c);
      if (c == CH_BSLASH) mode = M_WESC;
      else if (c == CH_SQUOTE) mode = M_SQ;
      else if (c == CH_DQUOTE) mode = M_DQ;
      else mode = M_WORD;
    endfunction

    // byte seen between tokens
    function void start_token(logic [7:0] c, logic [15:0] p);
      if (is_blank(c)) begin
      end else if (c == CH_NL) begin
        add_token(T_NEWLINE, p, next_pos(p) - p);
      end else if (c == CH_LPAREN) begin
        add_token(T_LPAREN, p, next_pos(p) - p);
      end else if (c == CH_RPAREN) begin
        add_token(T_RPAREN, p, next_pos(p) - p);
      end else if (op_of(c) != OP_NONE) begin
        pend_op = op_of(c);
        tok_begin = p;
      end else if (c == CH_HASH) begin
        mode = M_COMMENT;
      end else begin
        tok_begin = p;
        enter_word(c);
      end
    endfunction

    function void scan_byte(logic [7:0] c, logic [15:0] p);
      logic [4:0] t;
      case (mode)
        M_COMMENT: begin
          if (c == CH_NL) begin
            mode = M_IDLE;
            start_token(c, p);
          end
        end
        M_WORD: begin
          if (ends_word(c)) begin
            add_token(T_WORD, tok_begin, p - tok_begin);
            mode = M_IDLE;
            start_token(c, p);
          end else begin
            enter_word(c);
          end
        end
        M_WESC: mode = M_WORD;
        M_SQ: if (c == CH_SQUOTE) mode = M_WORD;
        M_DQ: begin
          if (c == CH_DQUOTE) mode = M_WORD;
          else if (c == CH_BSLASH) mode = M_DQESC;
        end
        M_DQESC: mode = M_DQ;
        default: begin
          mode = M_IDLE;
          if (pend_op == OP_NONE) begin
            start_token(c, p);
          end else if (pair_type(pend_op, c, t)) begin
            add_token(t, tok_begin, next_pos(p) - tok_begin);
            pend_op = OP_NONE;
          end else begin
            add_token(single_type(pend_op), tok_begin, p - tok_begin);
            pend_op = OP_NONE;
            start_token(c, p);
          end
        end
      endcase
    endfunction

    // accepted input beat: work out the tokens it owes
    function void note_beat(logic [7:0] ch, logic has, logic fin);
      step_q.delete();
      if (has) begin
        scan_byte(ch, line_pos);
        line_pos = next_pos(line_pos);
      end
      if (fin) begin
        if (pend_op != OP_NONE)
          add_token(single_type(pend_op), tok_begin, line_pos - tok_begin);
        else if (mode == M_WORD)
          add_token(T_WORD, tok_begin, line_pos - tok_begin);
        else if (mode == M_WESC || mode == M_SQ || mode == M_DQ || mode == M_DQESC)
          add_token(T_ERROR, tok_begin, line_pos - tok_begin);
        add_token(T_EOF, line_pos, 16'd0);
        clear_line();
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) owed_q.push_back(step_q[i]);
    endfunction

    function void check_token(logic [4:0] t, logic [15:0] s, logic [15:0] l, logic last);
      token_beat_t e;
      tokens_seen++;
      if (owed_q.size() == 0) begin
        $error("token with nothing owed: type %0d start %0d length %0d", t, s, l);
        mismatches++;
      end else begin
        e = owed_q.pop_front();
        kinds_seen[e.ttype] = 1'b1;
        if (t !== e.ttype) begin
          $error("token_type: expected %0d, got %0d", e.ttype, t);
          mismatches++;
        end
        if (s !== e.start) begin
          $error("token_start: expected %0d, got %0d", e.start, s);
          mismatches++;
        end
        if (l !== e.length) begin
          $error("token_length: expected %0d, got %0d", e.length, l);
          mismatches++;
        end
        if (last !== e.last) begin
          $error("last_of_run: expected %0d, got %0d", e.last, last);
          mismatches++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_ch;
  logic        in_has_char;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  out_token_type;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic        out_last_of_run;

  token_scoreboard book;
  bit          tx_gaps = 1'b1;       // sender may idle between beats
  bit          rx_gaps = 1'b1;       // receiver may stall before each token
  bit          hold_request = 1'b0;  // one long receiver hold-off
  int unsigned items_sent = 0;       // beats that carry a byte or close a line
  int unsigned lines_sent = 0;
  logic [7:0]  line_q[$];            // bytes of the command line being built

  // character pools for building lines
  logic [7:0] op_starts[8] = '{CH_PIPE, CH_AMP, CH_SEMI, CH_LT, CH_GT,
                               CH_LPAREN, CH_RPAREN, CH_NL};
  logic [7:0] blank_set[5] = '{CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};
  logic [7:0] word_marks[4] = '{8'h2D, 8'h2E, 8'h2F, 8'h3D};

  shell_command_tokenizer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_has_char      (in_has_char),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_type   (out_token_type),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the block hangs
  initial begin
    #10ms;
    $display("[shell_command_tokenizer] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------
  // line building helpers
  // ---------------------------------------------------------------

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  // a byte that keeps a word going and has no special meaning
  function automatic logic [7:0] plain_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'h61, 8'h7A));
      1:       return 8'($urandom_range(8'h30, 8'h39));
      2:       return word_marks[$urandom_range(0, 3)];
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  // word made of plain runs, inner hashes, escapes and closed quotes
  function automatic void put_word();
    int unsigned segs;
    logic [7:0]  b;
    segs = $urandom_range(1, 3);
    for (int unsigned i = 0; i < segs; i++) begin
      case ($urandom_range(0, 5))
        0, 1: repeat ($urandom_range(1, 4)) line_q.push_back(plain_byte());
        2: begin
          // hash inside a word is plain
          line_q.push_back(plain_byte());
          line_q.push_back(CH_HASH);
        end
        3: begin
          line_q.push_back(CH_BSLASH);
          line_q.push_back(any_byte());
        end
        4: begin
          line_q.push_back(CH_SQUOTE);
          repeat ($urandom_range(0, 4)) begin
            b = any_byte();
            line_q.push_back(b == CH_SQUOTE ? CH_DQUOTE : b);
          end
          line_q.push_back(CH_SQUOTE);
        end
        default: begin
          line_q.push_back(CH_DQUOTE);
          repeat ($urandom_range(0, 4)) begin
            b = any_byte();
            if (b == CH_DQUOTE || b == CH_BSLASH || $urandom_range(0, 3) == 0) begin
              // escaped byte inside double quotes
              line_q.push_back(CH_BSLASH);
              line_q.push_back(b);
            end else begin
              line_q.push_back(b);
            end
          end
          line_q.push_back(CH_DQUOTE);
        end
      endcase
    end
  endfunction

  // one operator byte, sometimes followed by a second that may pair with it
  function automatic void put_operator();
    logic [7:0] first;
    first = op_starts[$urandom_range(0, 7)];
    line_q.push_back(first);
    if ($urandom_range(0, 1) == 1)
      line_q.push_back($urandom_range(0, 1) == 1 ? first : CH_AMP);
  endfunction

  function automatic void put_blanks();
    repeat ($urandom_range(1, 2)) line_q.push_back(blank_set[$urandom_range(0, 4)]);
  endfunction

  function automatic void put_comment();
    logic [7:0] b;
    line_q.push_back(CH_HASH);
    repeat ($urandom_range(0, 5)) begin
      b = any_byte();
      line_q.push_back(b == CH_NL ? CH_SPACE : b);
    end
    line_q.push_back(CH_NL);
  endfunction

  // well-formed mix of words, operators, comments and blanks
  function automatic void build_sentence(int unsigned target);
    while (line_q.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          put_word();
          if ($urandom_range(0, 99) < 55) put_blanks();
        end
        4, 5, 6: put_operator();
        7:       put_comment();
        default: put_blanks();
      endcase
    end
  endfunction

  // ---------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------

  task automatic send_item(logic [7:0] c, logic has, logic fin);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_has_char <= has;
    in_end_of_input <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_beat(c, has, fin);
    if (has || fin) items_sent++;
  endtask

  // send line_q as one command line, closed on its last byte or by a bare marker
  task automatic send_line(bit bare_end);
    int unsigned n;
    n = line_q.size();
    for (int unsigned i = 0; i < n; i++) begin
      // stray empty beat, must be ignored
      if ($urandom_range(0, 39) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(line_q[i], 1'b1, !bare_end && i == n - 1);
    end
    if (bare_end || n == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    lines_sent++;
    line_q.delete();
  endtask

  // receiver: random stall ahead of each token, one long hold-off on request
  initial begin
    int unsigned wait_cycles;
    out_stall <= 1'b1;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      wait_cycles = rx_gaps ? $urandom_range(0, 9) : 0;
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      book.check_token(out_token_type, out_token_start, out_token_length, out_last_of_run);
    end
  end

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------
  initial begin
    int unsigned pick;
    book = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_ch <= 8'h00;
    in_has_char <= 1'b0;
    in_end_of_input <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every operator packed back to back; the last beat owes three tokens
    put_text("|||&&&;;;<<<&<>>>&\n)>(");
    send_line(1'b0);

    // ignored empty beat between lines
    send_item(8'h00, 1'b0, 1'b0);

    // top byte value, hash and pipe inside a word, cr/ff/vt as blanks,
    // comment up to newline, escaped quote inside an open double quote
    line_q = '{8'hFF, CH_HASH, CH_SQUOTE, CH_PIPE, CH_SQUOTE, CH_CR, CH_FF, CH_VT,
               CH_HASH, CH_NL, CH_DQUOTE, CH_BSLASH, CH_DQUOTE};
    send_line(1'b0);

    // line holding only the end marker
    send_line(1'b1);

    // byte 0x01, then a backslash left dangling at the end
    line_q = '{8'h01, CH_BSLASH};
    send_line(1'b0);

    // back-pressure: receiver holds off while operators keep streaming in
    hold_request = 1'b1;
    tx_gaps = 1'b0;
    repeat (16) begin
      line_q.push_back(plain_byte());
      line_q.push_back(CH_SEMI);
    end
    send_line(1'b0);

    // random lines, mostly well-formed with some noise and broken tails
    while (items_sent < 350) begin
      tx_gaps = $urandom_range(0, 4) != 0;
      rx_gaps = $urandom_range(0, 4) != 0;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 16)) line_q.push_back(any_byte());
      end else begin
        build_sentence($urandom_range(2, 20));
        if (pick == 1) begin
          // unterminated quote or escape at the end of the line
          case ($urandom_range(0, 3))
            0: begin
              line_q.push_back(CH_SQUOTE);
              line_q.push_back(plain_byte());
            end
            1: begin
              line_q.push_back(CH_DQUOTE);
              line_q.push_back(plain_byte());
            end
            2: line_q.push_back(CH_BSLASH);
            default: begin
              line_q.push_back(CH_DQUOTE);
              line_q.push_back(CH_BSLASH);
            end
          endcase
        end
      end
      send_line($urandom_range(0, 3) == 0);
    end

    // offsets must start over at zero on a fresh line
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    build_sentence(12);
    send_line(1'b1);

    in_valid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run: %0d command lines, %0d input beats, %0d tokens checked",
             lines_sent, items_sent, book.tokens_seen);
    $display("token kinds seen: %0d of 18, with gaps, stray empty beats and a long hold-off",
             $countones(book.kinds_seen));
    if (book.mismatches == 0) begin
      $display("[shell_command_tokenizer] OK");
    end else begin
      $display("[shell_command_tokenizer] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/sct_pkg.sv
hw/rtl/sct_front.sv
hw/rtl/sct_queue.sv
hw/rtl/sct_back.sv
hw/rtl/shell_command_tokenizer.sv
hw/rtl/sct_checker.sv
verif/shell_command_tokenizer_tb.sv
